/* hdl/bdlp_pkg.sv */
package bdlp_pkg;

    localparam int unsigned CountWidth = 16;
    localparam logic [CountWidth-1:0] DebounceTicksReset = 16'd40;
    localparam logic [CountWidth-1:0] LongPressTicksReset = 16'd3000;

    typedef enum logic [1:0] {
        ST_UP      = 2'd0,
        ST_FALLING = 2'd1,
        ST_DOWN    = 2'd2,
        ST_RISING  = 2'd3
    } btn_state_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic {
        REG_DEBOUNCE_TICKS   = 1'b0,
        REG_LONG_PRESS_TICKS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0] press_event;
        logic       debounced_down;
    } bdlp_result_t;

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        sat_inc = (v == {CountWidth{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

/* hdl/bdlp_fsm.sv */
module bdlp_fsm
    import bdlp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CountWidth-1:0] cfg_wdata,
    input  logic                  item_load,
    input  logic                  item_action,
    input  logic                  item_pin_level,
    output bdlp_result_t          result
);

    logic [CountWidth-1:0] debounce_ticks_reg;
    logic [CountWidth-1:0] long_press_ticks_reg;
    btn_state_t            state_reg, state_next;
    logic [CountWidth-1:0] debounce_count_reg, debounce_count_next;
    logic [CountWidth-1:0] hold_count_reg, hold_count_next;
    logic                  long_flag_reg, long_flag_next;
    press_event_t          latched_event_reg, latched_event_next;

    logic                  pressed;
    logic [CountWidth-1:0] debounce_inc;
    logic [CountWidth-1:0] hold_inc;
    logic                  debounce_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= DebounceTicksReset;
            long_press_ticks_reg <= LongPressTicksReset;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wdata;
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_UP;
            debounce_count_reg <= '0;
            hold_count_reg     <= '0;
            long_flag_reg      <= 1'b0;
            latched_event_reg  <= EV_NONE;
        end else if (item_load) begin
            state_reg          <= state_next;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
            long_flag_reg      <= long_flag_next;
            latched_event_reg  <= latched_event_next;
        end
    end

    assign pressed       = ~item_pin_level;
    assign debounce_inc  = sat_inc(debounce_count_reg);
    assign hold_inc      = sat_inc(hold_count_reg);
    assign debounce_done = (debounce_inc >= debounce_ticks_reg);

    always_comb begin
        state_next          = state_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        long_flag_next      = long_flag_reg;
        latched_event_next  = latched_event_reg;
        result.press_event  = EV_NONE;

        if (action_t'(item_action) == ACT_READ) begin
            // read and clear the event, time stands still
            result.press_event = latched_event_reg;
            latched_event_next = EV_NONE;
        end else begin
            unique case (state_reg)
                ST_UP: begin
                    if (pressed) begin
                        state_next          = ST_FALLING;
                        debounce_count_next = '0;
                    end
                end
                ST_FALLING: begin
                    debounce_count_next = debounce_inc;
                    if (debounce_done) begin
                        if (pressed) begin
                            state_next      = ST_DOWN;
                            long_flag_next  = 1'b0;
                            hold_count_next = '0;
                        end else begin
                            state_next = ST_UP;
                        end
                    end
                end
                ST_DOWN: begin
                    if (!pressed) begin
                        latched_event_next  = long_flag_reg ? EV_LONG : EV_SHORT;
                        state_next          = ST_RISING;
                        debounce_count_next = '0;
                    end else begin
                        hold_count_next = hold_inc;
                        if (hold_inc >= long_press_ticks_reg) begin
                            long_flag_next = 1'b1;
                        end
                    end
                end
                ST_RISING: begin
                    debounce_count_next = debounce_inc;
                    if (debounce_done) begin
                        state_next = ST_UP;
                    end
                end
                default: state_next = ST_UP;
            endcase
        end

        result.debounced_down = (state_next == ST_DOWN);
    end

endmodule

/* hdl/bdlp_out_reg.sv */
module bdlp_out_reg
    import bdlp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  bdlp_result_t load_data,
    input  logic         take,
    output logic         valid,
    output bdlp_result_t data
);

    logic         valid_reg, valid_next;
    bdlp_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hdl/button_debounce_long_press_core.sv */
// Channel   Direction  Payload
// s_axis    in         tuser: action; tdata: pin_level
// m_axis    out        tdata: press_event, debounced_down
// cfg       in         cfg_index 0 debounce_ticks, 1 long_press_ticks
//
// The state update and the result for each item are computed in one pass, and
// the result lands in the output register on the accepting edge.
// One item per cycle is sustained while m_axis_tready stays high; the single
// output register sets that rate, since s_axis_tready = !m_axis_tvalid || m_axis_tready.
// Synchronous active-low reset restores the idle up state and default timings.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] press_event, [2] debounced_down, [7:3] zero
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic         item_load;
    bdlp_result_t fsm_result;
    bdlp_result_t out_data;

    assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
    assign item_load     = s_axis_tvalid & s_axis_tready;

    bdlp_fsm u_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_load      (item_load),
        .item_action    (s_axis_tuser),
        .item_pin_level (s_axis_tdata[0]),
        .result         (fsm_result)
    );

    bdlp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (item_load),
        .load_data (fsm_result),
        .take      (m_axis_tready),
        .valid     (m_axis_tvalid),
        .data      (out_data)
    );

    assign m_axis_tdata = {5'b0, out_data.debounced_down, out_data.press_event};

endmodule
